// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// File: rtl/mavg_pkg.sv
package mavg_pkg;

    localparam int WINDOW_MAX  = 32;
    localparam int SAMPLE_BITS = 16;

    localparam int SLOT_BITS   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);
    localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS;
    localparam int DCNT_BITS   = $clog2(SUM_BITS + 1);
    localparam int CFG_BITS    = 6;

    localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(5);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } mavg_state_t;

    typedef struct packed {
        logic load;
        logic sum_en;
        logic div_start;
        logic div_en;
        logic out_load;
    } mavg_cmd_t;

    typedef struct packed {
        logic sum_done;
        logic div_done;
    } mavg_stat_t;

endpackage

// File: rtl/mavg_ctrl.sv
`include "assert_macros.svh"

module mavg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  mavg_pkg::mavg_stat_t stat,
    output mavg_pkg::mavg_cmd_t  cmd
);
    import mavg_pkg::*;

    mavg_state_t state_reg;
    mavg_state_t state_next;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic        out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (stat.sum_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SUM:
            begin
                cmd.sum_en    = 1'b1;
                cmd.div_start = stat.sum_done;
            end
            ST_DIV:
            begin
                cmd.div_en = 1'b1;
            end
            ST_DONE:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Hold the result until the consumer takes it.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    `ASSERT_NEXT(a_accept_to_sum, s_tvalid && s_tready, state_reg == ST_SUM,
                 "accepted sample did not start the summing pass")
    `ASSERT_NEXT(a_done_gives_result, state_reg == ST_DONE && out_free, m_tvalid_reg,
                 "finished item did not present a result")
    `ASSERT_CLK(a_div_only_after_sum, cmd.div_start |-> state_reg == ST_SUM,
                "divider started outside the summing pass")

endmodule

// File: rtl/mavg_dpath.sv
`include "assert_macros.svh"

module mavg_dpath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mavg_pkg::CFG_BITS-1:0]         cfg_wdata,
    input  logic signed [mavg_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                  first,
    input  mavg_pkg::mavg_cmd_t                   cmd,
    output mavg_pkg::mavg_stat_t                  stat,
    output logic signed [mavg_pkg::SAMPLE_BITS-1:0] average
);
    import mavg_pkg::*;

    logic signed [SAMPLE_BITS-1:0] ring [WINDOW_MAX];

    logic [CFG_BITS-1:0]    window_length_reg;
    logic [SLOT_BITS-1:0]   write_slot_reg;
    logic [CNT_BITS-1:0]    fill_count_reg;
    logic [CNT_BITS-1:0]    count_reg;
    logic [SLOT_BITS-1:0]   rd_ptr_reg;
    logic [SLOT_BITS-1:0]   reads_left_reg;
    logic [SLOT_BITS-1:0]   adds_left_reg;
    logic                   rd_vld_reg;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic signed [SUM_BITS-1:0]    window_sum_reg;
    logic [SUM_BITS-1:0]    quo_reg;
    logic [CNT_BITS-1:0]    rem_reg;
    logic [DCNT_BITS-1:0]   div_cnt_reg;
    logic                   neg_reg;
    logic signed [SAMPLE_BITS-1:0] average_reg;

    logic [SLOT_BITS-1:0]   slot;
    logic [CNT_BITS-1:0]    fill_next;
    logic [CNT_BITS-1:0]    eff_win;
    logic [CNT_BITS-1:0]    count_next;
    logic [CNT_BITS:0]      trial;
    logic [CNT_BITS:0]      diff;
    logic                   ge;
    logic [SUM_BITS-1:0]    result;

    always_comb
    begin
        slot = first ? '0 : write_slot_reg;
        if (first)
        begin
            fill_next = CNT_BITS'(1);
        end
        else if (fill_count_reg == CNT_BITS'(WINDOW_MAX))
        begin
            fill_next = fill_count_reg;
        end
        else
        begin
            fill_next = fill_count_reg + CNT_BITS'(1);
        end
        priority if (window_length_reg == '0)
        begin
            eff_win = CNT_BITS'(1);
        end
        else if (int'(window_length_reg) > WINDOW_MAX)
        begin
            eff_win = CNT_BITS'(WINDOW_MAX);
        end
        else
        begin
            eff_win = CNT_BITS'(window_length_reg);
        end
        count_next = (eff_win < fill_next) ? eff_win : fill_next;
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign trial  = {rem_reg, quo_reg[SUM_BITS-1]};
    assign diff   = trial - {1'b0, count_reg};
    assign ge     = trial >= {1'b0, count_reg};
    assign result = neg_reg ? -quo_reg : quo_reg;

    assign stat.sum_done = (adds_left_reg == '0);
    assign stat.div_done = (div_cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ring[slot] <= sample;
        end
        rd_data_reg <= ring[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_RESET;
            write_slot_reg    <= '0;
            fill_count_reg    <= '0;
            count_reg         <= CNT_BITS'(1);
            rd_ptr_reg        <= '0;
            reads_left_reg    <= '0;
            adds_left_reg     <= '0;
            rd_vld_reg        <= 1'b0;
            window_sum_reg    <= '0;
            div_cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_length_reg <= cfg_wdata;
            end
            rd_vld_reg <= 1'b0;
            if (cmd.load)
            begin
                write_slot_reg <= slot + SLOT_BITS'(1);
                fill_count_reg <= fill_next;
                count_reg      <= count_next;
                rd_ptr_reg     <= slot - SLOT_BITS'(1);
                reads_left_reg <= SLOT_BITS'(count_next - CNT_BITS'(1));
                adds_left_reg  <= SLOT_BITS'(count_next - CNT_BITS'(1));
                window_sum_reg <= {{SLOT_BITS{sample[SAMPLE_BITS-1]}}, sample};
            end
            if (cmd.sum_en)
            begin
                if (reads_left_reg != '0)
                begin
                    rd_ptr_reg     <= rd_ptr_reg - SLOT_BITS'(1);
                    reads_left_reg <= reads_left_reg - SLOT_BITS'(1);
                    rd_vld_reg     <= 1'b1;
                end
                if (rd_vld_reg)
                begin
                    window_sum_reg <= window_sum_reg
                                    + {{SLOT_BITS{rd_data_reg[SAMPLE_BITS-1]}}, rd_data_reg};
                    adds_left_reg  <= adds_left_reg - SLOT_BITS'(1);
                end
            end
            if (cmd.div_start)
            begin
                div_cnt_reg <= DCNT_BITS'(SUM_BITS);
            end
            else if (cmd.div_en && div_cnt_reg != '0)
            begin
                div_cnt_reg <= div_cnt_reg - DCNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            neg_reg <= window_sum_reg[SUM_BITS-1];
            quo_reg <= window_sum_reg[SUM_BITS-1] ? -window_sum_reg : window_sum_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_en && div_cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
            quo_reg <= {quo_reg[SUM_BITS-2:0], ge};
        end
        if (cmd.out_load)
        begin
            average_reg <= result[SAMPLE_BITS-1:0];
        end
    end

    assign average = average_reg;

    `ASSERT_CLK(a_read_in_sum, rd_vld_reg |-> $past(cmd.sum_en),
                "ring read issued outside the summing pass")
    `ASSERT_CLK(a_reads_lead_adds, reads_left_reg <= adds_left_reg,
                "more ring reads pending than additions")
    `ASSERT_CLK(a_quotient_range,
                (cmd.div_en && stat.div_done)
                    |-> quo_reg <= SUM_BITS'(1 << (SAMPLE_BITS - 1)),
                "mean magnitude exceeds the sample range")

endmodule

// File: rtl/moving_average_filter_core.sv
// Moving-average filter with warm-up. Each input transfer carries one signed
// Q1.15 sample in s_tdata and a start-of-signal flag in s_tuser; each item
// produces exactly one output transfer with the mean of the latest
// min(samples since start, window_length) samples, truncated toward zero.
// Reset acts as a start of signal, and window_length resets to 5 (zero is
// taken as 1, values above 32 as 32); a new window applies from the next
// item on. Items are handled one at a time.
// The newest sample goes straight into the running sum. The N - 1 older
// averaged samples come out of the 32-entry history RAM, which has one read
// port, reads one entry per cycle and registers its read data. The
// shift-subtract divider then runs 21 quotient steps and a last check that
// the step count has run out. Then the output register is loaded; the
// item waits while the output register stays full. The next sample is
// accepted while a finished result still waits in the output register.

module moving_average_filter_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration: window_length
    input  logic                             cfg_we,
    input  logic [mavg_pkg::CFG_BITS-1:0]    cfg_wdata,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mavg_pkg::SAMPLE_BITS-1:0] s_tdata,   // [15:0] sample
    input  logic                             s_tuser,   // [0] first
    // Output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mavg_pkg::SAMPLE_BITS-1:0] m_tdata    // [15:0] average
);
    import mavg_pkg::*;

    mavg_cmd_t                     cmd;
    mavg_stat_t                    stat;
    logic signed [SAMPLE_BITS-1:0] average;

    // Sequence each item: accept, sum, divide, hand off.
    mavg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // History RAM, running sum, fill count and divider.
    mavg_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample    (s_tdata),
        .first     (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .average   (average)
    );

    assign m_tdata = average;

endmodule

// File: tb/tb_moving_average_filter_core.sv
`timescale 1ns / 100ps

module tb_moving_average_filter_core;

    import mavg_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 9;
    localparam int IDLE_PCT     = 8;
    // Idle time after the last average, with margin over the longest item.
    localparam int DRAIN_CYCLES = 80;
    localparam int TARGET_ITEMS = 1000;
    localparam int QUIET_PHASE  = 6;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

    // Expected averages of the moving-average filter, with its own copy of
    // the sample history, fill count, write slot and window register.
    class mavg_scoreboard;
        logic signed [SAMPLE_BITS-1:0] history [WINDOW_MAX];
        int unsigned                   fill;
        int unsigned                   slot;
        logic [CFG_BITS-1:0]           window;
        logic [SAMPLE_BITS-1:0]        avg_queue [$];
        int                            mismatches;

        function new();
            fill       = 0;
            slot       = 0;
            window     = WINDOW_RESET;
            mismatches = 0;
            foreach (history[i])
                history[i] = '0;
        endfunction

        function void set_window(logic [CFG_BITS-1:0] value);
            window = value;
        endfunction

        function int pending();
            return avg_queue.size();
        endfunction

        // Take in one accepted sample and queue the average it must produce.
        function void note_input(logic [SAMPLE_BITS-1:0] smp, logic fst);
            int unsigned span;
            int          total;
            int          mean;
            if (fst)
            begin
                fill = 0;
                slot = 0;
            end
            history[slot] = smp;
            slot = (slot + 1) % WINDOW_MAX;
            if (fill < WINDOW_MAX)
                fill++;
            // Zero counts as one, anything above the ring depth saturates.
            if (window == 0)
                span = 1;
            else if (window > WINDOW_MAX)
                span = WINDOW_MAX;
            else
                span = window;
            if (span > fill)
                span = fill;
            total = 0;
            for (int j = 0; j < span; j++)
                total += history[(slot + WINDOW_MAX - 1 - j) % WINDOW_MAX];
            // Integer division in SV truncates toward zero, as required.
            mean = total / int'(span);
            avg_queue.push_back(SAMPLE_BITS'(mean));
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [SAMPLE_BITS-1:0] avg);
            logic [SAMPLE_BITS-1:0] want;
            if (avg_queue.size() == 0)
            begin
                report_mismatch($sformatf("average %0d with nothing expected",
                                          $signed(avg)));
            end
            else
            begin
                want = avg_queue.pop_front();
                if (avg !== want)
                    report_mismatch($sformatf("average got %0d expected %0d",
                                              $signed(avg), $signed(want)));
            end
        endtask
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_BITS-1:0]    cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [SAMPLE_BITS-1:0] s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b1;
    logic [SAMPLE_BITS-1:0] m_tdata;

    // Hold both sides free of idle cycles while set.
    bit                     no_idle   = 1'b0;
    int                     sent_count = 0;

    mavg_scoreboard sb = new();

    moving_average_filter_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [15:0] sample
        .s_tuser   (s_tuser),    // [0] first
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)     // [15:0] average
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Drop the run if it hangs; normal runs finish far below this.
    initial
    begin
        #(20_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    // Output side: check every transfer, then stall at random for the next edge.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata);
            m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Offer one sample and hold it until the transfer happens. Valid is left
    // high on return so a back-to-back item keeps it up without a glitch.
    task send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic fst);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= fst;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(smp, fst);
        sent_count++;
    endtask

    // Lower valid and wait until every expected average has arrived, then let
    // the block settle.
    task drain_filter();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write window_length while the block is idle; it applies from the next item.
    task write_window(input logic [CFG_BITS-1:0] value);
        drain_filter();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_window(value);
    endtask

    function logic [SAMPLE_BITS-1:0] pick_sample();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_BITS'($urandom_range(0, 8) - 4);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    initial
    begin
        int unsigned            seg_len;
        int unsigned            phase;
        logic [CFG_BITS-1:0]    win;
        logic [SAMPLE_BITS-1:0] level;
        bit                     flat;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, default window of 5. Start without the first flag, since
        // reset alone must open a new signal.
        repeat (6) send_sample(SAMPLE_MAX, 1'b0);
        repeat (3) send_sample(SAMPLE_MIN, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hffff, 1'b0);
        send_sample(16'h0001, 1'b0);
        // Restart mid-run: warm-up must count from one again.
        send_sample(16'hffff, 1'b1);
        // (1 - 2) / 2 truncates to 0, (1 - 2 - 2) / 3 to -1.
        send_sample(16'h0001, 1'b1);
        send_sample(16'hfffe, 1'b0);
        send_sample(16'hfffe, 1'b0);

        // Window edge cases, changed in mid-signal without a restart.
        write_window(6'd0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(16'h0007, 1'b0);
        write_window(6'd63);
        send_sample(SAMPLE_MAX, 1'b0);
        write_window(6'd1);
        send_sample(16'h5555, 1'b0);
        write_window(6'd33);
        send_sample(16'haaaa, 1'b0);

        // Full window of the most negative sample: largest magnitude sum.
        write_window(6'd32);
        send_sample(SAMPLE_MIN, 1'b1);
        repeat (33) send_sample(SAMPLE_MIN, 1'b0);
        repeat (33) send_sample(SAMPLE_MAX, 1'b0);

        // Random phases: new window each time, history mostly carried over.
        phase = 0;
        while (sent_count < TARGET_ITEMS)
        begin
            if ($urandom_range(0, 9) < 3)
                win = ($urandom_range(0, 1) != 0) ? 6'd32 : 6'($urandom_range(0, 1) * 63);
            else
                win = 6'($urandom_range(0, 63));
            write_window(win);
            no_idle = (phase == QUIET_PHASE);
            flat    = ($urandom_range(0, 9) == 0);
            level   = ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
            seg_len = $urandom_range(20, 80);
            for (int i = 0; i < seg_len; i++)
            begin
                if (flat)
                    send_sample(level, (i == 0) ? 1'b1 : 1'b0);
                else
                    send_sample(pick_sample(),
                                ((i == 0) ? $urandom_range(0, 1) : 0) != 0 ||
                                $urandom_range(0, 99) < 3);
            end
            no_idle = 1'b0;
            phase++;
        end

        drain_filter();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
